[rtl/core/nbg_pkg.sv]
// shared types, constants and helper functions for the n-body gravity stepper
// no dependencies; imported by every module of the block but nbg_check
package nbg_pkg;

	// default sizing, handed down from the top level
	localparam int MAX_BODIES_DEF = 16;
	localparam int FRAC_BITS_DEF  = 24;

	// configuration register indexes and reset values
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_GRAV  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd2;
	localparam logic [31:0] GRAV_RESET  = 32'd4371;
	localparam logic [31:0] DT_RESET    = 32'd11767536;
	localparam logic [4:0]  COUNT_RESET = 5'd2;

	// one stored body
	typedef struct packed {
		logic [31:0]        mass;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
	} body_t;

	// datapath operations issued by the controller
	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_READ,
		OP_TAKE_I,
		OP_DIFF,
		OP_SQ_X,
		OP_SQ_Y,
		OP_SQ_SUM,
		OP_ROOT_GO,
		OP_ROOT_TAKE,
		OP_MUL_GM,
		OP_MUL_KLO,
		OP_MUL_KHI,
		OP_K_SUM,
		OP_DIV_F_GO,
		OP_F_TAKE,
		OP_MUL_FX,
		OP_DIV_X_GO,
		OP_ACC_X,
		OP_MUL_FY,
		OP_DIV_Y_GO,
		OP_ACC_Y,
		OP_VEL,
		OP_MUL_DX,
		OP_DRIFT_X,
		OP_MUL_DY,
		OP_DRIFT_Y,
		OP_WRITE
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   last;
	} dp_cmd_t;

	typedef struct packed {
		logic       sq_zero;
		logic       root_done;
		logic       div_done;
		logic       out_free;
		logic [4:0] body_count;
	} dp_status_t;

	// clamp a wide signed value to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		else if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction

	// magnitude of a signed 32-bit value as unsigned
	function automatic logic [31:0] abs32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : v;
	endfunction

endpackage

[rtl/core/nbg_sqrt.sv]
// bit-pair iterative integer square root of a 64-bit value
// one result bit per iteration, from two radicand bits at a time; uses nbg_pkg
module nbg_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic [31:0] root,
	output logic        done
);
	import nbg_pkg::*;

	logic [63:0] x_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] trial;
	logic        ge;

	// trial subtraction for this bit pair
	assign trial = res_q + bit_q;
	assign ge    = (x_q >= trial);

	// iteration registers
	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= radicand;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (ge) begin
				x_q   <= x_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	// busy and done flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q && bit_q[0]) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end
	end

	assign root = res_q[31:0];
	assign done = done_q;

endmodule

[rtl/core/nbg_div.sv]
// restoring bit-serial divider, one quotient bit per cycle
// quotient clamped to 32 bits unsigned; uses nbg_pkg
module nbg_div #(
	parameter int DW = 90
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [63:0]   divisor,
	output logic [31:0]   quotient,
	output logic          done
);
	import nbg_pkg::*;

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] num_q;
	logic [63:0]   den_q;
	logic [63:0]   rem_q;
	logic [31:0]   quo_q;
	logic          over_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [64:0]   tmp;
	logic          ge;
	logic [63:0]   rem_n;

	// shift in the next dividend bit and try the subtraction
	always_comb begin
		tmp   = {rem_q, num_q[DW-1]};
		ge    = (tmp >= {1'b0, den_q});
		rem_n = ge ? 64'(tmp - {1'b0, den_q}) : tmp[63:0];
	end

	// working registers
	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= dividend;
			den_q  <= divisor;
			rem_q  <= '0;
			quo_q  <= '0;
			over_q <= 1'b0;
		end else if (busy_q) begin
			num_q  <= num_q << 1;
			rem_q  <= rem_n;
			quo_q  <= {quo_q[30:0], ge};
			over_q <= over_q | quo_q[31];
		end
	end

	// bit counter and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(DW);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign quotient = over_q ? 32'hFFFF_FFFF : quo_q;
	assign done     = done_q;

endmodule

[rtl/core/nbg_datapath.sv]
// datapath: body table, configuration registers, shared multiplier,
// square root and divider units, output register; uses nbg_pkg, nbg_sqrt, nbg_div
module nbg_datapath #(
	parameter int MAX_BODIES = nbg_pkg::MAX_BODIES_DEF,
	parameter int FRAC_BITS  = nbg_pkg::FRAC_BITS_DEF,
	parameter int IW         = $clog2(MAX_BODIES)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  nbg_pkg::dp_cmd_t                 cmd,
	input  logic [IW-1:0]                    addr,
	output nbg_pkg::dp_status_t              status,
	input  logic [3:0]                       body_index,
	input  logic [31:0]                      body_mass,
	input  logic signed [31:0]               start_pos_x,
	input  logic signed [31:0]               start_pos_y,
	input  logic signed [31:0]               start_vel_x,
	input  logic signed [31:0]               start_vel_y,
	input  logic                             cfg_valid,
	input  logic [nbg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                      cfg_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [3:0]                       out_index,
	output logic signed [31:0]               out_pos_x,
	output logic signed [31:0]               out_pos_y,
	output logic signed [31:0]               out_vel_x,
	output logic signed [31:0]               out_vel_y,
	output logic                             last_body
);
	import nbg_pkg::*;

	localparam int KSHIFT = 3 * FRAC_BITS - 46;
	localparam int DW     = 64 + KSHIFT;
	localparam int ACC_W  = IW + 33;

	// configuration registers
	logic [31:0] grav_q;
	logic [31:0] dt_q;
	logic [4:0]  count_q;

	// body table with per-entry valid bits
	body_t                 mem_q [MAX_BODIES];
	logic [MAX_BODIES-1:0] valid_q;
	body_t                 rd_q;
	logic                  rd_valid_q;
	body_t                 rd_body;
	logic                  wr_en;
	logic [IW-1:0]         wr_addr;
	body_t                 wr_data;
	logic                  load_ok;

	// working registers
	logic [31:0]              cur_m_q;
	logic signed [31:0]       cur_px_q, cur_py_q, cur_vx_q, cur_vy_q;
	logic signed [31:0]       dx_q, dy_q;
	logic [63:0]              p_q, sq_q, a_q, k_q;
	logic [31:0]              r_q, f_q;
	logic signed [ACC_W-1:0]  acc_x_q, acc_y_q;
	logic [31:0]              mul_a, mul_b;
	logic [31:0]              dx_mag, dy_mag;
	logic signed [63:0]       drift;

	// output register
	logic                     out_valid_q;

	// shared units
	logic          root_start;
	logic [31:0]   root;
	logic          root_done;
	logic          div_start;
	logic [DW-1:0] div_num;
	logic [63:0]   div_den;
	logic [31:0]   div_quo;
	logic          div_done;

	assign dx_mag  = abs32(dx_q);
	assign dy_mag  = abs32(dy_q);
	assign rd_body = rd_valid_q ? rd_q : '0;
	assign load_ok = (int'(body_index) < MAX_BODIES);

	// table write port: loads and end-of-body updates
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr;
		wr_data = '{mass: cur_m_q, px: cur_px_q, py: cur_py_q, vx: cur_vx_q, vy: cur_vy_q};
		case (cmd.op)
			OP_LOAD: begin
				wr_en   = load_ok;
				wr_addr = IW'(body_index);
				wr_data = '{mass: body_mass, px: start_pos_x, py: start_pos_y,
					vx: start_vel_x, vy: start_vel_y};
			end
			OP_WRITE: begin
				wr_en = 1'b1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (cmd.op == OP_READ)
			rd_q <= mem_q[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en)
				valid_q[wr_addr] <= 1'b1;
			if (cmd.op == OP_READ)
				rd_valid_q <= valid_q[addr];
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q  <= GRAV_RESET;
			dt_q    <= DT_RESET;
			count_q <= COUNT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_GRAV:  grav_q  <= cfg_data;
				REG_DT:    dt_q    <= cfg_data;
				REG_COUNT: count_q <= cfg_data[4:0];
				default:   ;
			endcase
		end
	end

	// operand select for the shared 32x32 multiplier
	always_comb begin
		case (cmd.op)
			OP_SQ_X:    begin mul_a = dx_mag;      mul_b = dx_mag;       end
			OP_SQ_Y:    begin mul_a = dy_mag;      mul_b = dy_mag;       end
			OP_MUL_GM:  begin mul_a = grav_q;      mul_b = rd_body.mass; end
			OP_MUL_KLO: begin mul_a = a_q[31:0];   mul_b = dt_q;         end
			OP_MUL_KHI: begin mul_a = a_q[63:32];  mul_b = dt_q;         end
			OP_MUL_FX:  begin mul_a = f_q;         mul_b = dx_mag;       end
			OP_MUL_FY:  begin mul_a = f_q;         mul_b = dy_mag;       end
			OP_MUL_DX:  begin mul_a = abs32(cur_vx_q); mul_b = dt_q;     end
			OP_MUL_DY:  begin mul_a = abs32(cur_vy_q); mul_b = dt_q;     end
			default:    begin mul_a = '0;          mul_b = '0;           end
		endcase
	end

	// divider operand select
	always_comb begin
		div_start = (cmd.op == OP_DIV_F_GO) || (cmd.op == OP_DIV_X_GO) ||
			(cmd.op == OP_DIV_Y_GO);
		if (cmd.op == OP_DIV_F_GO) begin
			div_num = {k_q, KSHIFT'(0)};
			div_den = sq_q;
		end else begin
			div_num = DW'(p_q);
			div_den = {32'd0, r_q};
		end
	end

	assign root_start = (cmd.op == OP_ROOT_GO);
	assign drift      = signed'({32'd0, p_q[63:32]});

	// working register updates
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_TAKE_I: begin
				cur_m_q  <= rd_body.mass;
				cur_px_q <= rd_body.px;
				cur_py_q <= rd_body.py;
				cur_vx_q <= rd_body.vx;
				cur_vy_q <= rd_body.vy;
				acc_x_q  <= '0;
				acc_y_q  <= '0;
			end
			OP_DIFF: begin
				dx_q <= sat32(64'(rd_body.px) - 64'(cur_px_q));
				dy_q <= sat32(64'(rd_body.py) - 64'(cur_py_q));
			end
			OP_SQ_X:      p_q <= mul_a * mul_b;
			OP_SQ_Y: begin
				sq_q <= p_q;
				p_q  <= mul_a * mul_b;
			end
			OP_SQ_SUM:    sq_q <= sq_q + p_q;
			OP_ROOT_TAKE: r_q  <= root;
			OP_MUL_GM:    a_q  <= mul_a * mul_b;
			OP_MUL_KLO:   p_q  <= mul_a * mul_b;
			OP_MUL_KHI: begin
				k_q <= {32'd0, p_q[63:32]};
				p_q <= mul_a * mul_b;
			end
			OP_K_SUM:     k_q <= k_q + p_q;
			OP_F_TAKE:    f_q <= div_quo;
			OP_MUL_FX:    p_q <= mul_a * mul_b;
			OP_MUL_FY:    p_q <= mul_a * mul_b;
			OP_ACC_X: acc_x_q <= acc_x_q + (dx_q[31] ? -ACC_W'(div_quo) : ACC_W'(div_quo));
			OP_ACC_Y: acc_y_q <= acc_y_q + (dy_q[31] ? -ACC_W'(div_quo) : ACC_W'(div_quo));
			OP_VEL: begin
				cur_vx_q <= sat32(64'(cur_vx_q) + 64'(acc_x_q));
				cur_vy_q <= sat32(64'(cur_vy_q) + 64'(acc_y_q));
			end
			OP_MUL_DX:    p_q <= mul_a * mul_b;
			OP_MUL_DY:    p_q <= mul_a * mul_b;
			OP_DRIFT_X: cur_px_q <= sat32(cur_vx_q[31] ? 64'(cur_px_q) - drift
				: 64'(cur_px_q) + drift);
			OP_DRIFT_Y: cur_py_q <= sat32(cur_vy_q[31] ? 64'(cur_py_q) - drift
				: 64'(cur_py_q) + drift);
			default: ;
		endcase
	end

	// result register towards the master side
	always_ff @(posedge clk) begin
		if (cmd.op == OP_WRITE) begin
			out_index <= 4'(addr);
			out_pos_x <= cur_px_q;
			out_pos_y <= cur_py_q;
			out_vel_x <= cur_vx_q;
			out_vel_y <= cur_vy_q;
			last_body <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.op == OP_WRITE)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;

	nbg_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (sq_q),
		.root     (root),
		.done     (root_done)
	);

	nbg_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.quotient (div_quo),
		.done     (div_done)
	);

	// status back to the controller
	assign status = '{sq_zero: (sq_q == 64'd0), root_done: root_done, div_done: div_done,
		out_free: (!out_valid_q || out_ready), body_count: count_q};

endmodule

[rtl/core/nbg_ctrl.sv]
// controller: sequences loads and time steps over body and pair loops
// drives the datapath by command, watches its status; uses nbg_pkg
module nbg_ctrl #(
	parameter int MAX_BODIES = nbg_pkg::MAX_BODIES_DEF,
	parameter int IW         = $clog2(MAX_BODIES)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_action,
	output logic                in_ready,
	input  nbg_pkg::dp_status_t status,
	output nbg_pkg::dp_cmd_t    cmd,
	output logic [IW-1:0]       addr
);
	import nbg_pkg::*;

	typedef enum logic [28:0] {
		S_IDLE       = 29'h0000001,
		S_RD_I       = 29'h0000002,
		S_TAKE_I     = 29'h0000004,
		S_PAIR       = 29'h0000008,
		S_DIFF       = 29'h0000010,
		S_SQ_X       = 29'h0000020,
		S_SQ_Y       = 29'h0000040,
		S_SQ_SUM     = 29'h0000080,
		S_SQ_CHK     = 29'h0000100,
		S_ROOT_WAIT  = 29'h0000200,
		S_MUL_GM     = 29'h0000400,
		S_MUL_KLO    = 29'h0000800,
		S_MUL_KHI    = 29'h0001000,
		S_K_SUM      = 29'h0002000,
		S_DIV_F_GO   = 29'h0004000,
		S_DIV_F_WAIT = 29'h0008000,
		S_MUL_FX     = 29'h0010000,
		S_DIV_X_GO   = 29'h0020000,
		S_DIV_X_WAIT = 29'h0040000,
		S_MUL_FY     = 29'h0080000,
		S_DIV_Y_GO   = 29'h0100000,
		S_DIV_Y_WAIT = 29'h0200000,
		S_JNEXT      = 29'h0400000,
		S_VEL        = 29'h0800000,
		S_MUL_DX     = 29'h1000000,
		S_DRIFT_X    = 29'h2000000,
		S_MUL_DY     = 29'h4000000,
		S_DRIFT_Y    = 29'h8000000,
		S_WRITE      = 29'h10000000
	} state_t;

	state_t        state_q, state_n;
	logic [IW-1:0] i_q, j_q, last_q;
	logic [IW-1:0] last_n;
	logic          accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// index of the final active body from the count register
	always_comb begin
		if (status.body_count == 5'd0)
			last_n = '0;
		else if (int'(status.body_count) > MAX_BODIES)
			last_n = IW'(MAX_BODIES - 1);
		else
			last_n = IW'(status.body_count - 5'd1);
	end

	// next state and command
	always_comb begin
		state_n  = state_q;
		cmd.op   = OP_NOP;
		cmd.last = (i_q == last_q);
		addr     = i_q;
		case (state_q)
			S_IDLE: begin
				if (accept && in_action)
					state_n = S_RD_I;
				else if (accept)
					cmd.op = OP_LOAD;
			end
			S_RD_I: begin
				cmd.op  = OP_READ;
				state_n = S_TAKE_I;
			end
			S_TAKE_I: begin
				cmd.op  = OP_TAKE_I;
				state_n = S_PAIR;
			end
			S_PAIR: begin
				if (j_q == i_q) begin
					state_n = S_JNEXT;
				end else begin
					cmd.op  = OP_READ;
					addr    = j_q;
					state_n = S_DIFF;
				end
			end
			S_DIFF: begin
				cmd.op  = OP_DIFF;
				state_n = S_SQ_X;
			end
			S_SQ_X: begin
				cmd.op  = OP_SQ_X;
				state_n = S_SQ_Y;
			end
			S_SQ_Y: begin
				cmd.op  = OP_SQ_Y;
				state_n = S_SQ_SUM;
			end
			S_SQ_SUM: begin
				cmd.op  = OP_SQ_SUM;
				state_n = S_SQ_CHK;
			end
			S_SQ_CHK: begin
				// coincident pair pulls nothing
				if (status.sq_zero) begin
					state_n = S_JNEXT;
				end else begin
					cmd.op  = OP_ROOT_GO;
					state_n = S_ROOT_WAIT;
				end
			end
			S_ROOT_WAIT: begin
				if (status.root_done) begin
					cmd.op  = OP_ROOT_TAKE;
					state_n = S_MUL_GM;
				end
			end
			S_MUL_GM: begin
				cmd.op  = OP_MUL_GM;
				state_n = S_MUL_KLO;
			end
			S_MUL_KLO: begin
				cmd.op  = OP_MUL_KLO;
				state_n = S_MUL_KHI;
			end
			S_MUL_KHI: begin
				cmd.op  = OP_MUL_KHI;
				state_n = S_K_SUM;
			end
			S_K_SUM: begin
				cmd.op  = OP_K_SUM;
				state_n = S_DIV_F_GO;
			end
			S_DIV_F_GO: begin
				cmd.op  = OP_DIV_F_GO;
				state_n = S_DIV_F_WAIT;
			end
			S_DIV_F_WAIT: begin
				if (status.div_done) begin
					cmd.op  = OP_F_TAKE;
					state_n = S_MUL_FX;
				end
			end
			S_MUL_FX: begin
				cmd.op  = OP_MUL_FX;
				state_n = S_DIV_X_GO;
			end
			S_DIV_X_GO: begin
				cmd.op  = OP_DIV_X_GO;
				state_n = S_DIV_X_WAIT;
			end
			S_DIV_X_WAIT: begin
				if (status.div_done) begin
					cmd.op  = OP_ACC_X;
					state_n = S_MUL_FY;
				end
			end
			S_MUL_FY: begin
				cmd.op  = OP_MUL_FY;
				state_n = S_DIV_Y_GO;
			end
			S_DIV_Y_GO: begin
				cmd.op  = OP_DIV_Y_GO;
				state_n = S_DIV_Y_WAIT;
			end
			S_DIV_Y_WAIT: begin
				if (status.div_done) begin
					cmd.op  = OP_ACC_Y;
					state_n = S_JNEXT;
				end
			end
			S_JNEXT: begin
				state_n = (j_q == last_q) ? S_VEL : S_PAIR;
			end
			S_VEL: begin
				cmd.op  = OP_VEL;
				state_n = S_MUL_DX;
			end
			S_MUL_DX: begin
				cmd.op  = OP_MUL_DX;
				state_n = S_DRIFT_X;
			end
			S_DRIFT_X: begin
				cmd.op  = OP_DRIFT_X;
				state_n = S_MUL_DY;
			end
			S_MUL_DY: begin
				cmd.op  = OP_MUL_DY;
				state_n = S_DRIFT_Y;
			end
			S_DRIFT_Y: begin
				cmd.op  = OP_DRIFT_Y;
				state_n = S_WRITE;
			end
			S_WRITE: begin
				// wait for room in the result register
				if (status.out_free) begin
					cmd.op  = OP_WRITE;
					state_n = (i_q == last_q) ? S_IDLE : S_RD_I;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	// state and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			last_q  <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == S_IDLE && accept && in_action) begin
				i_q    <= '0;
				last_q <= last_n;
			end
			if (state_q == S_TAKE_I)
				j_q <= '0;
			if (state_q == S_JNEXT && j_q != last_q)
				j_q <= j_q + 1'b1;
			if (state_q == S_WRITE && status.out_free && i_q != last_q)
				i_q <= i_q + 1'b1;
		end
	end

endmodule

[rtl/core/nbody_gravity_step.sv]
// A load is written into the body table as it is accepted. A step runs over the
// active bodies and every ordered pair of them, its length set mainly by the
// bit-serial divider shared by the three divisions of a pair.
// Throughput: one item at a time; the next item is taken once the last result is queued.
// Reset: asynchronous, active low; registers return to their reset values, the body
// table reads as zero until written.
module nbody_gravity_step #(
	parameter int MAX_BODIES = nbg_pkg::MAX_BODIES_DEF,
	parameter int FRAC_BITS  = nbg_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// body_index[3:0], body_mass[35:4], start_pos_x[67:36], start_pos_y[99:68],
	// start_vel_x[131:100], start_vel_y[163:132], zero[167:164]
	input  logic [167:0]                  s_axis_tdata,
	// action
	input  logic                          s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// out_index[3:0], out_pos_x[35:4], out_pos_y[67:36], out_vel_x[99:68],
	// out_vel_y[131:100], zero[135:132]
	output logic [135:0]                  m_axis_tdata,
	output logic                          m_axis_tlast,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [nbg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	import nbg_pkg::*;

	localparam int IW = $clog2(MAX_BODIES);

	dp_cmd_t            cmd;
	dp_status_t         status;
	logic [IW-1:0]      addr;
	logic [3:0]         out_index;
	logic signed [31:0] out_pos_x, out_pos_y, out_vel_x, out_vel_y;

	// configuration writes always land at once
	assign cfg_ready = 1'b1;

	nbg_ctrl #(.MAX_BODIES(MAX_BODIES), .IW(IW)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_action (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.status    (status),
		.cmd       (cmd),
		.addr      (addr)
	);

	nbg_datapath #(.MAX_BODIES(MAX_BODIES), .FRAC_BITS(FRAC_BITS), .IW(IW)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.addr        (addr),
		.status      (status),
		.body_index  (s_axis_tdata[3:0]),
		.body_mass   (s_axis_tdata[35:4]),
		.start_pos_x (s_axis_tdata[67:36]),
		.start_pos_y (s_axis_tdata[99:68]),
		.start_vel_x (s_axis_tdata[131:100]),
		.start_vel_y (s_axis_tdata[163:132]),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_index   (out_index),
		.out_pos_x   (out_pos_x),
		.out_pos_y   (out_pos_y),
		.out_vel_x   (out_vel_x),
		.out_vel_y   (out_vel_y),
		.last_body   (m_axis_tlast)
	);

	// pack the result transaction
	assign m_axis_tdata = {4'd0, out_vel_y, out_vel_x, out_pos_y, out_pos_x, out_index};

endmodule

[rtl/core/nbg_check.sv]
// port-level checks for the n-body gravity stepper, bound to the top level
// depends only on the top level's ports
module nbg_check (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         s_axis_tuser,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [135:0] m_axis_tdata,
	input logic         m_axis_tlast
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// a step keeps the input side closed
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
		else $error("input open right after a step transaction");

	// a load leaves the input side open
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> s_axis_tready)
		else $error("input closed after a load transaction");

	// results before the last one of a step come while the input is closed
	a_mid_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) && !m_axis_tlast |-> !s_axis_tready)
		else $error("input open during a step");

endmodule

bind nbody_gravity_step nbg_check u_check (.*);

[test/testbench.sv]
// self-checking testbench for the n-body gravity stepper: loads bodies, runs steps,
// predicts every body result in fixed point and checks the stream output
// depends on nbg_pkg and nbody_gravity_step
`timescale 1ns / 100ps

module testbench;
	import nbg_pkg::*;

	localparam int NB = 16;
	localparam int KSH = 3 * 24 - 46;
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_ADVANCE = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam longint CYCLE_LIMIT = 64000000;
	localparam int LONG_HOLD = 3000;
	localparam longint S32_HI = 64'sd2147483647;
	localparam longint S32_LO = -64'sd2147483648;

	typedef struct packed {
		logic [3:0]  idx;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] vx;
		logic [31:0] vy;
		logic        last;
	} body_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [167:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [135:0] m_axis_tdata;
	logic m_axis_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// predictor state
	bit [31:0] grav_g, step_dt;
	bit [4:0] active_count;
	longint pos_x[NB], pos_y[NB], vel_x[NB], vel_y[NB];
	bit [63:0] mass[NB];

	body_report_t body_reports_q[$];
	int errors = 0;
	longint cycles = 0;
	int stall_hold = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int items_sent = 0;

	nbody_gravity_step DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout at %0t", $time);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// mostly short random stalls, rarely long, with a counted hold-off
	always @(posedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (hold_requests != hold_served) begin
			hold_served <= hold_requests;
			stall_hold <= LONG_HOLD;
			m_axis_tready <= 1'b0;
		end else if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
			m_axis_tready <= 1'b0;
		end else if (r < 60)
			m_axis_tready <= 1'b1;
		else if (r < 97)
			m_axis_tready <= 1'b0;
		else begin
			stall_hold <= $urandom_range(10, 40);
			m_axis_tready <= 1'b0;
		end
	end

	function automatic longint clamp32(longint v);
		if (v > S32_HI) return S32_HI;
		if (v < S32_LO) return S32_LO;
		return v;
	endfunction

	function automatic bit [63:0] root64(bit [63:0] x);
		bit [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	// floor(k * 2^KSH / sq), clamped to 32 bits
	function automatic bit [63:0] pull_strength(bit [63:0] k, bit [63:0] sq);
		bit [127:0] q;
		q = ({64'd0, k} << KSH) / {64'd0, sq};
		return (q > 128'hFFFF_FFFF) ? 64'hFFFF_FFFF : q[63:0];
	endfunction

	function automatic longint pair_pull(bit [63:0] f, longint d, bit [63:0] r);
		bit [63:0] mag, v;
		mag = (d < 0) ? -d : d;
		v = (f * mag) / r;
		return (d < 0) ? -longint'(v) : longint'(v);
	endfunction

	function automatic longint drift_of(longint v);
		bit [63:0] mag;
		longint m;
		mag = (v < 0) ? -v : v;
		m = longint'((mag * {32'd0, step_dt}) >> 32);
		return (v < 0) ? -m : m;
	endfunction

	// one explicit step over the active bodies, queuing one report per body
	task automatic advance_bodies();
		int n;
		longint ax, ay, dx, dy;
		bit [63:0] sq, r, gm, k, f;
		body_report_t rep;
		n = active_count;
		if (n == 0) n = 1;
		if (n > NB) n = NB;
		for (int i = 0; i < n; i++) begin
			ax = 0;
			ay = 0;
			for (int j = 0; j < n; j++) begin
				if (j == i) continue;
				dx = clamp32(pos_x[j] - pos_x[i]);
				dy = clamp32(pos_y[j] - pos_y[i]);
				sq = 64'(dx * dx) + 64'(dy * dy);
				if (sq == 0) continue;
				r = root64(sq);
				gm = {32'd0, grav_g} * mass[j];
				k = (gm >> 32) * {32'd0, step_dt} + (({32'd0, gm[31:0]} * {32'd0, step_dt}) >> 32);
				f = pull_strength(k, sq);
				ax += pair_pull(f, dx, r);
				ay += pair_pull(f, dy, r);
			end
			vel_x[i] = clamp32(vel_x[i] + ax);
			vel_y[i] = clamp32(vel_y[i] + ay);
			pos_x[i] = clamp32(pos_x[i] + drift_of(vel_x[i]));
			pos_y[i] = clamp32(pos_y[i] + drift_of(vel_y[i]));
			rep.idx = 4'(i);
			rep.px = pos_x[i][31:0];
			rep.py = pos_y[i][31:0];
			rep.vx = vel_x[i][31:0];
			rep.vy = vel_y[i][31:0];
			rep.last = (i == n - 1);
			body_reports_q.push_back(rep);
		end
	endtask

	task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		body_report_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (body_reports_q.size() == 0) begin
				$display("%0t: unexpected result, got %h", $time, m_axis_tdata);
				errors++;
			end else begin
				exp_r = body_reports_q.pop_front();
				report_field("index", 32'(exp_r.idx), 32'(m_axis_tdata[3:0]));
				report_field("pos_x", exp_r.px, m_axis_tdata[35:4]);
				report_field("pos_y", exp_r.py, m_axis_tdata[67:36]);
				report_field("vel_x", exp_r.vx, m_axis_tdata[99:68]);
				report_field("vel_y", exp_r.vy, m_axis_tdata[131:100]);
				report_field("last", 32'(exp_r.last), 32'(m_axis_tlast));
			end
		end
	end

	// sends one item; valid stays high across back-to-back transactions
	task automatic send_item(logic act, logic [3:0] idx, logic [31:0] m,
			logic [31:0] px, logic [31:0] py, logic [31:0] vx, logic [31:0] vy);
		int gap;
		gap = ($urandom_range(0, 9) < 4) ? 0 :
			(($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3));
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata <= {4'd0, vy, vx, py, px, m, idx};
		s_axis_tuser <= act;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
		if (act == ACT_ADVANCE)
			advance_bodies();
		else begin
			mass[idx] = {32'd0, m};
			pos_x[idx] = longint'(signed'(px));
			pos_y[idx] = longint'(signed'(py));
			vel_x[idx] = longint'(signed'(vx));
			vel_y[idx] = longint'(signed'(vy));
		end
	endtask

	// wait for every expected result, then let the block settle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (body_reports_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_GRAV:  grav_g = val;
			REG_DT:    step_dt = val;
			REG_COUNT: active_count = val[4:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic [31:0] near_pos();
		return 32'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000;
	endfunction

	task automatic load_body(logic [3:0] idx, bit wild);
		if (wild)
			send_item(ACT_LOAD, idx, $urandom, $urandom, $urandom, $urandom, $urandom);
		else
			send_item(ACT_LOAD, idx, $urandom_range(0, 32'h8000_0000),
				near_pos(), near_pos(), near_pos() >>> 2, near_pos() >>> 2);
	endtask

	// field extremes, zero distance, zero mass and inactive bodies
	task automatic test_field_extremes();
		send_item(ACT_ADVANCE, 4'd0, '0, '0, '0, '0, '0);
		send_item(ACT_LOAD, 4'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000);
		send_item(ACT_LOAD, 4'd1, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF);
		send_item(ACT_ADVANCE, 4'd0, '0, '0, '0, '0, '0);
		// two bodies on the same spot
		send_item(ACT_LOAD, 4'd0, 32'h4000_0000, 32'h0100_0000, 32'h0, 32'h0, 32'h0);
		send_item(ACT_LOAD, 4'd1, 32'h4000_0000, 32'h0100_0000, 32'h0, 32'h0, 32'h0);
		send_item(ACT_LOAD, 4'd15, 32'h4000_0000, 32'h0, 32'h0200_0000, 32'h0, 32'h0);
		send_item(ACT_ADVANCE, 4'd15, '0, '0, '0, '0, '0);
		send_item(ACT_LOAD, 4'd1, 32'h4000_0000, 32'h0, 32'h0100_0000, 32'h0, 32'h0);
		send_item(ACT_ADVANCE, 4'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain();
	endtask

	// every register, extremes of each and the unused index
	task automatic test_registers();
		write_reg(REG_COUNT, 32'd0);
		write_reg(REG_UNUSED, $urandom);
		send_item(ACT_ADVANCE, 4'd0, '0, '0, '0, '0, '0);
		drain();
		write_reg(REG_GRAV, 32'hFFFF_FFFF);
		write_reg(REG_DT, 32'hFFFF_FFFF);
		write_reg(REG_COUNT, 32'd31);
		for (int i = 0; i < NB; i++) load_body(4'(i), i[0]);
		send_item(ACT_ADVANCE, 4'd0, '0, '0, '0, '0, '0);
		drain();
		write_reg(REG_GRAV, 32'd0);
		write_reg(REG_DT, 32'd0);
		write_reg(REG_COUNT, 32'd3);
		send_item(ACT_ADVANCE, 4'd0, '0, '0, '0, '0, '0);
		drain();
		write_reg(REG_GRAV, 32'd4371 << 8);
		write_reg(REG_DT, 32'h1000_0000);
		write_reg(REG_COUNT, 32'd16);
		send_item(ACT_ADVANCE, 4'd0, '0, '0, '0, '0, '0);
		drain();
	endtask

	// long receiver hold-off while items keep coming
	task automatic test_backpressure();
		write_reg(REG_COUNT, 32'd3);
		hold_requests++;
		for (int i = 0; i < 4; i++) begin
			load_body(4'($urandom_range(0, 2)), 1'b0);
			send_item(ACT_ADVANCE, 4'd0, '0, '0, '0, '0, '0);
		end
		drain();
	endtask

	// random phases of settings, loads and steps
	task automatic test_random_phases();
		int goal, n;
		goal = items_sent + 110;
		while (items_sent < goal) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
			write_reg(REG_COUNT, n);
			if ($urandom_range(0, 1)) write_reg(REG_GRAV, $urandom_range(0, 32'h0010_0000));
			if ($urandom_range(0, 1)) write_reg(REG_DT, $urandom);
			repeat ($urandom_range(1, n + 2))
				load_body(4'($urandom_range(0, 15)), $urandom_range(0, 4) == 0);
			repeat ($urandom_range(1, 3)) begin
				send_item(ACT_ADVANCE, 4'($urandom), $urandom, $urandom, $urandom,
					$urandom, $urandom);
				if ($urandom_range(0, 2) == 0) load_body(4'($urandom_range(0, 15)), 1'b0);
			end
			if ($urandom_range(0, 2) == 0) drain();
			drain();
		end
	endtask

	initial begin
		grav_g = GRAV_RESET;
		step_dt = DT_RESET;
		active_count = COUNT_RESET;
		for (int i = 0; i < NB; i++) begin
			pos_x[i] = 0; pos_y[i] = 0; vel_x[i] = 0; vel_y[i] = 0; mass[i] = 0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_field_extremes();
		test_registers();
		test_backpressure();
		test_random_phases();
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[files.f]
rtl/core/nbg_pkg.sv
rtl/core/nbg_sqrt.sv
rtl/core/nbg_div.sv
rtl/core/nbg_datapath.sv
rtl/core/nbg_ctrl.sv
rtl/core/nbody_gravity_step.sv
rtl/core/nbg_check.sv
test/testbench.sv
